@@ hdl/utp_pkg.sv @@
// ----------------------------------------------------------------------------
// utp_pkg
// Shared types and constants of the identifier text parser: layout
// positions, character codes, result format codes and the per-character
// check result.
// ----------------------------------------------------------------------------
`default_nettype none

package utp_pkg;

	localparam int unsigned POS_W = 6;

	localparam logic [POS_W-1:0] POS_SAT    = 6'd39;
	localparam logic [POS_W-1:0] BRACED_LEN = 6'd38;
	localparam logic [POS_W-1:0] PLAIN_LEN  = 6'd36;

	// hyphen positions of the braced layout
	localparam logic [POS_W-1:0] BR_HYP0 = 6'd9;
	localparam logic [POS_W-1:0] BR_HYP1 = 6'd14;
	localparam logic [POS_W-1:0] BR_HYP2 = 6'd19;
	localparam logic [POS_W-1:0] BR_HYP3 = 6'd24;

	// hyphen positions of the plain layout
	localparam logic [POS_W-1:0] PL_HYP0 = 6'd8;
	localparam logic [POS_W-1:0] PL_HYP1 = 6'd13;
	localparam logic [POS_W-1:0] PL_HYP2 = 6'd18;
	localparam logic [POS_W-1:0] PL_HYP3 = 6'd23;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;
	localparam logic [7:0] CH_DIG0   = 8'h30;
	localparam logic [7:0] CH_DIG9   = 8'h39;
	localparam logic [7:0] CH_LOWA   = 8'h61;
	localparam logic [7:0] CH_LOWF   = 8'h66;
	localparam logic [7:0] CH_UPA    = 8'h41;
	localparam logic [7:0] CH_UPF    = 8'h46;

	typedef enum logic [1:0] {
		FMT_INVALID = 2'd0,
		FMT_BRACED  = 2'd1,
		FMT_PLAIN   = 2'd2
	} fmt_t;

	typedef struct packed {
		logic       hex;
		logic [3:0] nibble;
		logic       braced_acc;
		logic       plain_acc;
	} chk_t;

endpackage

`default_nettype wire

@@ hdl/utp_char_check.sv @@
// ----------------------------------------------------------------------------
// utp_char_check
// Classifies one character at a given position: hex digit and its value,
// and whether each of the two layouts accepts it there.
// ----------------------------------------------------------------------------
`default_nettype none

module utp_char_check (
	input  wire logic [7:0]               char_code,
	input  wire logic [utp_pkg::POS_W-1:0] pos,
	output utp_pkg::chk_t                 chk
);
	import utp_pkg::*;

	logic       is_dig;
	logic       is_low;
	logic       is_up;
	logic [7:0] sub;
	logic       br_hyp;
	logic       pl_hyp;

	always_comb begin
		is_dig = (char_code >= CH_DIG0) && (char_code <= CH_DIG9);
		is_low = (char_code >= CH_LOWA) && (char_code <= CH_LOWF);
		is_up  = (char_code >= CH_UPA)  && (char_code <= CH_UPF);

		// offset that maps the character onto its digit value
		priority if (is_dig) begin
			sub = char_code - CH_DIG0;
		end else if (is_low) begin
			sub = char_code - (CH_LOWA - 8'd10);
		end else begin
			sub = char_code - (CH_UPA - 8'd10);
		end

		br_hyp = (pos == BR_HYP0) || (pos == BR_HYP1) || (pos == BR_HYP2) || (pos == BR_HYP3);
		pl_hyp = (pos == PL_HYP0) || (pos == PL_HYP1) || (pos == PL_HYP2) || (pos == PL_HYP3);

		chk.hex    = is_dig || is_low || is_up;
		chk.nibble = sub[3:0];

		priority if (pos >= BRACED_LEN) begin
			chk.braced_acc = 1'b0;
		end else if (pos == '0) begin
			chk.braced_acc = (char_code == CH_LBRACE);
		end else if (pos == BRACED_LEN - 6'd1) begin
			chk.braced_acc = (char_code == CH_RBRACE);
		end else if (br_hyp) begin
			chk.braced_acc = (char_code == CH_HYPHEN);
		end else begin
			chk.braced_acc = chk.hex;
		end

		priority if (pos >= PLAIN_LEN) begin
			chk.plain_acc = 1'b0;
		end else if (pl_hyp) begin
			chk.plain_acc = (char_code == CH_HYPHEN);
		end else begin
			chk.plain_acc = chk.hex;
		end
	end

endmodule

`default_nettype wire

@@ hdl/uuid_text_parser.sv @@
// Result path: the transfer of the last character loads the input register;
// it advances into the result register once that register is empty or taken.
// Throughput: one character per cycle, except that a last character waits
// while the result register is full and not taken; the per-character check
// and 4-bit shift of the 128-bit accumulator fit between the two registers.
// Reset: arst_n clears position, accumulator and valid bits and sets both
// layout flags.
// ----------------------------------------------------------------------------
// uuid_text_parser
// Parses an 8-4-4-4-12 hex identifier string, braced or plain, one
// character per transfer, and reports the format and the 128-bit value.
// ----------------------------------------------------------------------------
`default_nettype none

module uuid_text_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       format_code,
	output logic [63:0]      value_upper,
	output logic [63:0]      value_lower
);
	import utp_pkg::*;

	// input register
	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             last_s1;

	// parse state
	logic [POS_W-1:0] pos_q;
	logic             braced_q;
	logic             plain_q;
	logic [127:0]     accum_q;

	// result register
	logic             out_valid_q;
	fmt_t             fmt_q;
	logic [127:0]     value_q;

	chk_t             chk;
	logic             adv;
	logic             braced_nx;
	logic             plain_nx;
	logic [127:0]     accum_nx;
	fmt_t             fmt_nx;

	utp_char_check u_check (
		.char_code (char_s1),
		.pos       (pos_q),
		.chk       (chk)
	);

	// Advance the held character unless it would produce a result while the
	// result register is still full and not being taken.
	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_comb begin
		braced_nx = braced_q && chk.braced_acc;
		plain_nx  = plain_q && chk.plain_acc;
		// shift in one nibble, most significant first
		accum_nx  = chk.hex ? {accum_q[123:0], chk.nibble} : accum_q;

		// braced layout wins over plain; lengths exclude each other anyway
		priority if (braced_nx && (pos_q == BRACED_LEN - 6'd1)) begin
			fmt_nx = FMT_BRACED;
		end else if (plain_nx && (pos_q == PLAIN_LEN - 6'd1)) begin
			fmt_nx = FMT_PLAIN;
		end else begin
			fmt_nx = FMT_INVALID;
		end
	end

	// Input register: load on every transfer, drop once advanced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			last_s1 <= is_last;
		end
	end

	// Parse state: advance on each character; return to the start after the
	// last one so the next string begins fresh.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			braced_q <= 1'b1;
			plain_q  <= 1'b1;
			accum_q  <= '0;
		end else if (adv) begin
			if (last_s1) begin
				pos_q    <= '0;
				braced_q <= 1'b1;
				plain_q  <= 1'b1;
				accum_q  <= '0;
			end else begin
				// hold the count once it reaches saturation
				if (pos_q != POS_SAT) begin
					pos_q <= pos_q + 6'd1;
				end
				braced_q <= braced_nx;
				plain_q  <= plain_nx;
				accum_q  <= accum_nx;
			end
		end
	end

	// Result register: fill on a last character, clear when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			fmt_q   <= fmt_nx;
			// zero the value of an invalid string
			value_q <= (fmt_nx != FMT_INVALID) ? accum_nx : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign format_code = fmt_q;
	assign value_upper = value_q[127:64];
	assign value_lower = value_q[63:0];

	// An invalid result always carries a zero value.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (format_code == FMT_INVALID)) |-> ((value_upper == '0) && (value_lower == '0)))
		else $error("invalid result with nonzero value");

	// The position counter never passes saturation.
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_SAT)
		else $error("position counter beyond saturation");

	// After the last character the parser is back at its start state.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> ((pos_q == '0) && braced_q && plain_q && (accum_q == '0)))
		else $error("parser not restarted after last character");

	// A finished result loads the result register on the next edge.
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> out_valid_q)
		else $error("result lost");

endmodule

`default_nettype wire
